// ===== rtl/bpi_pkg.sv =====
`default_nettype none

package bpi_pkg;

    // Datapath operations issued by the sequencer, one per cycle.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD_ROW,
        OP_LOAD_COL,
        OP_COEF,
        OP_MUL,
        OP_ADD_E,
        OP_ADD_D,
        OP_ADD_P1,
        OP_STORE,
        OP_RESULT
    } op_t;

    // Number of kept row values before the column pass.
    localparam int unsigned ROWS_KEPT = 3;

    typedef struct packed {
        op_t        op;
        logic [1:0] slot;   // row slot written by OP_STORE
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bpi_ctrl.sv =====
`default_nettype none

module bpi_ctrl
    import bpi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF,
        ST_MUL1,
        ST_ADD1,
        ST_MUL2,
        ST_ADD2,
        ST_MUL3,
        ST_ADD3,
        ST_WRAP
    } state_t;

    state_t     state_reg;
    logic [1:0] row_idx_reg;
    logic       col_pass_reg;
    logic       out_valid_reg;

    logic       last_row;
    logic       out_free;

    assign last_row  = (row_idx_reg == 2'(ROWS_KEPT));
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op   = OP_IDLE;
        cmd.slot = row_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD_ROW;
                end
            end
            ST_COEF: cmd.op = OP_COEF;
            ST_MUL1: cmd.op = OP_MUL;
            ST_ADD1: cmd.op = OP_ADD_E;
            ST_MUL2: cmd.op = OP_MUL;
            ST_ADD2: cmd.op = OP_ADD_D;
            ST_MUL3: cmd.op = OP_MUL;
            ST_ADD3: cmd.op = OP_ADD_P1;
            ST_WRAP:
            begin
                if (!col_pass_reg)
                begin
                    cmd.op = last_row ? OP_LOAD_COL : OP_STORE;
                end
                else if (out_free)
                begin
                    cmd.op = OP_RESULT;
                end
            end
            default: cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_idx_reg   <= 2'd0;
            col_pass_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new result takes the output register in the same cycle that the
            // waiting one leaves it, so setting wins over clearing.
            if ((state_reg == ST_WRAP) && col_pass_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_COEF;
                        col_pass_reg <= 1'b0;
                    end
                end
                ST_COEF: state_reg <= ST_MUL1;
                ST_MUL1: state_reg <= ST_ADD1;
                ST_ADD1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_ADD2;
                ST_ADD2: state_reg <= ST_MUL3;
                ST_MUL3: state_reg <= ST_ADD3;
                ST_ADD3: state_reg <= ST_WRAP;
                ST_WRAP:
                begin
                    if (!col_pass_reg)
                    begin
                        if (last_row)
                        begin
                            col_pass_reg <= 1'b1;
                            state_reg    <= ST_COEF;
                        end
                        else
                        begin
                            row_idx_reg <= row_idx_reg + 2'd1;
                            state_reg   <= ST_IDLE;
                        end
                    end
                    else if (out_free)
                    begin
                        row_idx_reg   <= 2'd0;
                        col_pass_reg  <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bpi_datapath.sv =====
`default_nettype none

module bpi_datapath
    import bpi_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned FRAC_BITS   = 16
)
(
    input  wire logic                   clk,
    input  wire cmd_t                   cmd,
    input  wire logic [SAMPLE_BITS-1:0] sample_a,
    input  wire logic [SAMPLE_BITS-1:0] sample_b,
    input  wire logic [SAMPLE_BITS-1:0] sample_c,
    input  wire logic [SAMPLE_BITS-1:0] sample_d,
    input  wire logic [FRAC_BITS-1:0]   frac_col,
    input  wire logic [FRAC_BITS-1:0]   frac_row,
    output logic      [SAMPLE_BITS-1:0] interp_value
);

    // Row values stay within about -0.15 to 1.15 of full scale, so two bits of
    // headroom hold them. Horner intermediates need eight bits over the sample.
    localparam int unsigned PW    = SAMPLE_BITS + 2;
    localparam int unsigned XW    = SAMPLE_BITS + 8;
    localparam int unsigned PRODW = XW + FRAC_BITS + 1;

    logic signed [PW-1:0]      p_reg [4];
    logic signed [PW-1:0]      part_reg [ROWS_KEPT];
    logic [FRAC_BITS-1:0]      t_reg;
    logic [FRAC_BITS-1:0]      frac_row_reg;
    logic signed [XW-1:0]      d_reg;
    logic signed [XW-1:0]      e_reg;
    logic signed [XW-1:0]      p1_reg;
    logic signed [XW-1:0]      acc_reg;
    logic signed [PRODW-1:0]   prod_reg;
    logic [SAMPLE_BITS-1:0]    result_reg;

    logic signed [XW-1:0]      px [4];
    logic signed [XW-1:0]      d_next;
    logic signed [XW-1:0]      e_next;
    logic signed [XW-1:0]      f_next;
    logic signed [FRAC_BITS:0] t_s;
    logic signed [PRODW-1:0]   prod_next;
    logic signed [PRODW-1:0]   rnd_f;
    logic signed [PRODW-1:0]   rnd_f1;
    logic signed [XW-1:0]      rnd_f_x;
    logic signed [XW-1:0]      rnd_f1_x;
    logic [SAMPLE_BITS-1:0]    clip_value;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            px[i] = {{(XW-PW){p_reg[i][PW-1]}}, p_reg[i]};
        end
    end

    assign d_next = px[2] - px[0];
    assign e_next = (px[0] <<< 1) - ((px[1] <<< 2) + px[1]) + (px[2] <<< 2) - px[3];
    assign f_next = ((px[1] - px[2]) <<< 1) + (px[1] - px[2]) + px[3] - px[0];

    assign t_s       = $signed({1'b0, t_reg});
    assign prod_next = acc_reg * t_s;

    // Round half toward +inf: add half an LSB, then shift arithmetically.
    assign rnd_f    = (prod_reg + (PRODW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rnd_f1   = (prod_reg + (PRODW'(1) <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    assign rnd_f_x  = rnd_f[XW-1:0];
    assign rnd_f1_x = rnd_f1[XW-1:0];

    always_comb
    begin
        priority if (acc_reg[XW-1])
        begin
            clip_value = '0;
        end
        else if (|acc_reg[XW-2:SAMPLE_BITS])
        begin
            clip_value = '1;
        end
        else
        begin
            clip_value = acc_reg[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD_ROW:
            begin
                p_reg[0]     <= $signed({2'b00, sample_a});
                p_reg[1]     <= $signed({2'b00, sample_b});
                p_reg[2]     <= $signed({2'b00, sample_c});
                p_reg[3]     <= $signed({2'b00, sample_d});
                t_reg        <= frac_col;
                frac_row_reg <= frac_row;
            end
            OP_LOAD_COL:
            begin
                p_reg[0] <= part_reg[0];
                p_reg[1] <= part_reg[1];
                p_reg[2] <= part_reg[2];
                p_reg[3] <= acc_reg[PW-1:0];
                t_reg    <= frac_row_reg;
            end
            OP_COEF:
            begin
                d_reg   <= d_next;
                e_reg   <= e_next;
                p1_reg  <= px[1];
                acc_reg <= f_next;
            end
            OP_MUL:    prod_reg <= prod_next;
            OP_ADD_E:  acc_reg  <= e_reg + rnd_f_x;
            OP_ADD_D:  acc_reg  <= d_reg + rnd_f_x;
            OP_ADD_P1: acc_reg  <= p1_reg + rnd_f1_x;
            OP_STORE:
            begin
                if (cmd.slot < 2'(ROWS_KEPT))
                begin
                    part_reg[cmd.slot] <= acc_reg[PW-1:0];
                end
            end
            OP_RESULT: result_reg <= clip_value;
            OP_IDLE:   ;
            default:   ;
        endcase
    end

    assign interp_value = result_reg;

endmodule

`default_nettype wire

// ===== rtl/bicubic_patch_interpolator_top.sv =====
// A new row request is taken only once the sequencer is idle again: after the cubic of
// the current row is done, and on a fourth row after the column cubic has filled the output register.
// The pace is set by the single shared multiplier, used three times per cubic with a
// register after each product, and by the extra column cubic on the fourth row.
// Reset (rst_n, asynchronous, active low) clears the sequencer, the row counter and
// the output valid flag; the kept row values need no reset and are written before use.
`default_nettype none

module bicubic_patch_interpolator_top
    import bpi_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 24,
    parameter int unsigned FRAC_BITS   = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,

    // Slave side: one request is one row of the 4x4 patch.
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // Fields from bit 0 up: sample_a, sample_b, sample_c, sample_d, frac_col,
    // frac_row, then zero padding to a whole byte.
    input  wire logic [((4*SAMPLE_BITS+2*FRAC_BITS+7)/8)*8-1:0] s_axis_tdata,

    // Master side: one interpolated value per patch.
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // Fields from bit 0 up: interp_value, then zero padding to a whole byte.
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

    localparam int unsigned OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    cmd_t                   cmd;
    logic [SAMPLE_BITS-1:0] interp_value;

    // The sequencer walks each cubic through coefficient setup and three
    // multiply/accumulate steps, keeps rows 0 to 2, and on row 3 runs the
    // same cubic down the column before loading the output register. It can
    // take new rows while a finished result still waits on the master side.
    bpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    // The datapath holds the operands, the shared multiplier, the kept row
    // values and the output register with clipping and saturation.
    bpi_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .sample_a     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .sample_b     (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .sample_c     (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .sample_d     (s_axis_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS]),
        .frac_col     (s_axis_tdata[4*SAMPLE_BITS+FRAC_BITS-1:4*SAMPLE_BITS]),
        .frac_row     (s_axis_tdata[4*SAMPLE_BITS+2*FRAC_BITS-1:4*SAMPLE_BITS+FRAC_BITS]),
        .interp_value (interp_value)
    );

    assign m_axis_tdata = OUT_W'(interp_value);

endmodule

`default_nettype wire

// ===== test/tb_bicubic_patch_interpolator_top.sv =====
`timescale 1ns / 1ps

module tb_bicubic_patch_interpolator_top;

    // Block geometry at the default parameters.
    localparam int unsigned SAMPLE_BITS = 24;
    localparam int unsigned FRAC_BITS   = 16;
    localparam int unsigned IN_BITS     = ((4*SAMPLE_BITS+2*FRAC_BITS+7)/8)*8;
    localparam int unsigned OUT_BITS    = ((SAMPLE_BITS+7)/8)*8;

    // Largest sample and the rounding offsets of the two shift amounts used by the cubic.
    localparam logic [23:0] SMAX = 24'hFFFFFF;
    localparam longint SAMPLE_MAX = (64'sd1 <<< SAMPLE_BITS) - 64'sd1;
    localparam longint RND_F  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint RND_F1 = 64'sd1 <<< FRAC_BITS;

    // Random patches per idling phase; three phases give about 960 row requests.
    localparam int PATCHES_PER_PHASE = 80;
    // The receiver holds off this long once, so that the block backs up into its input.
    localparam int HOLD_CYCLES = 600;
    // Cycles without any accepted request, on either side, that end the run as hung.
    localparam int STALL_LIMIT = 5000;
    // Quiet cycles after the last result.
    localparam int DRAIN_CYCLES = 60;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    // One row of the directed table. The expected value is only meaningful on the fourth
    // row of a patch, and only used where known_val is set; otherwise the predictor decides.
    typedef struct packed {
        logic [23:0] s0;
        logic [23:0] s1;
        logic [23:0] s2;
        logic [23:0] s3;
        logic [15:0] fcol;
        logic [15:0] frow;
        logic        known_val;
        logic [23:0] val;
    } patch_row_t;

    // Six patches of four rows each.
    patch_row_t directed_rows [0:23] = '{
        // All-zero patch at both fraction extremes. Rows 0..2 carry a row fraction that
        // must be ignored.
        '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'hFFFF, 1'b0, 24'h0},
        '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'hFFFF, 16'h0000, 1'b0, 24'h0},
        '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'hFFFF, 16'hFFFF, 1'b0, 24'h0},
        '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'h0000, 16'h0000, 1'b1, 24'h0},
        // A constant patch at full scale reproduces itself for any fractions.
        '{SMAX, SMAX, SMAX, SMAX, 16'hFFFF, 16'h0000, 1'b0, 24'h0},
        '{SMAX, SMAX, SMAX, SMAX, 16'hFFFF, 16'h5555, 1'b0, 24'h0},
        '{SMAX, SMAX, SMAX, SMAX, 16'hFFFF, 16'hAAAA, 1'b0, 24'h0},
        '{SMAX, SMAX, SMAX, SMAX, 16'hFFFF, 16'hFFFF, 1'b1, SMAX},
        // A hump in every row overshoots the top of the range at mid column, and the column
        // pass of equal row values keeps that overshoot, so the output saturates.
        '{24'h000000, SMAX, SMAX, 24'h000000, 16'h8000, 16'hFFFF, 1'b0, 24'h0},
        '{24'h000000, SMAX, SMAX, 24'h000000, 16'h8000, 16'h0001, 1'b0, 24'h0},
        '{24'h000000, SMAX, SMAX, 24'h000000, 16'h8000, 16'h7FFF, 1'b0, 24'h0},
        '{24'h000000, SMAX, SMAX, 24'h000000, 16'h8000, 16'h1234, 1'b1, SMAX},
        // The mirrored dip undershoots zero, so the output is clipped to zero.
        '{SMAX, 24'h000000, 24'h000000, SMAX, 16'h8000, 16'h0000, 1'b0, 24'h0},
        '{SMAX, 24'h000000, 24'h000000, SMAX, 16'h8000, 16'hFFFF, 1'b0, 24'h0},
        '{SMAX, 24'h000000, 24'h000000, SMAX, 16'h8000, 16'h8000, 1'b0, 24'h0},
        '{SMAX, 24'h000000, 24'h000000, SMAX, 16'h8000, 16'hC3A5, 1'b1, 24'h0},
        // Zero fractions select the second sample of the second row.
        '{24'hFFFFFF, 24'h111111, 24'h000000, 24'hABCDEF, 16'h0000, 16'hFFFF, 1'b0, 24'h0},
        '{24'h000000, 24'h5A5A5A, 24'hFFFFFF, 24'h000000, 16'h0000, 16'hFFFF, 1'b0, 24'h0},
        '{24'h800000, 24'h7FFFFF, 24'h000001, 24'hFFFFFE, 16'h0000, 16'h8000, 1'b0, 24'h0},
        '{24'h123456, 24'hFEDCBA, 24'h654321, 24'h0F0F0F, 16'h0000, 16'h0000, 1'b1, 24'h5A5A5A},
        // A checkerboard of extremes with the largest and smallest nonzero fractions.
        '{SMAX, 24'h000000, SMAX, 24'h000000, 16'hFFFF, 16'h0001, 1'b0, 24'h0},
        '{24'h000000, SMAX, 24'h000000, SMAX, 16'h0001, 16'hFFFF, 1'b0, 24'h0},
        '{SMAX, 24'h000000, SMAX, 24'h000000, 16'hFFFF, 16'h0001, 1'b0, 24'h0},
        '{24'h000000, SMAX, 24'h000000, SMAX, 16'h0001, 16'hFFFF, 1'b0, 24'h0}
    };

    // Predictor state: which row of the patch comes next and the kept row values.
    logic [1:0]  patch_row;
    longint      row_values [3];
    // Interpolated values still owed by the block, oldest first.
    logic [23:0] expected_values [$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_armed    = 1'b0;
    bit hold_taken    = 1'b0;
    int hold_left     = 0;
    int stall_cycles  = 0;
    logic [23:0] owed_value;

    bicubic_patch_interpolator_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Catmull-Rom cubic through p0..p3 at t in Q0.16, in integer sample units. Each product
    // with t is rounded half up; the arithmetic shift of a signed value is a floor, which is
    // exactly the rounding the block must reproduce for negative intermediates.
    function automatic longint catmull_rom(input longint p0, input longint p1,
                                           input longint p2, input longint p3,
                                           input longint t);
        longint d, e, f, u, v;
        d = p2 - p0;
        e = 2*p0 - 5*p1 + 4*p2 - p3;
        f = 3*(p1 - p2) + p3 - p0;
        u = e + ((f*t + RND_F) >>> FRAC_BITS);
        v = d + ((u*t + RND_F) >>> FRAC_BITS);
        return p1 + ((v*t + RND_F1) >>> (FRAC_BITS + 1));
    endfunction

    // Fractions favor the two ends and the midpoint, the rest are uniform.
    function automatic logic [15:0] pick_frac();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one patch row and waits for the block to take it. An idle gap, drawn per cycle
    // at the sender's current rate, comes first; with no gap tvalid simply stays high. Once
    // the request is taken the predictor advances, and the fourth row of a patch queues the
    // value the block owes: the typed-in one where given, else the predicted one.
    task automatic send_row(input logic [23:0] sa, input logic [23:0] sb,
                            input logic [23:0] sc, input logic [23:0] sd,
                            input logic [15:0] fcol, input logic [15:0] frow,
                            input bit known_val, input logic [23:0] val);
        int gap;
        longint rv, res;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frow, fcol, sd, sc, sb, sa};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);

        rv = catmull_rom(longint'(sa), longint'(sb), longint'(sc), longint'(sd),
                         longint'(fcol));
        if (patch_row < 2'd3)
        begin
            row_values[patch_row] = rv;
            patch_row = patch_row + 2'd1;
        end
        else
        begin
            res = catmull_rom(row_values[0], row_values[1], row_values[2], rv,
                              longint'(frow));
            if (res < 0)
                res = 0;
            else if (res > SAMPLE_MAX)
                res = SAMPLE_MAX;
            expected_values.push_back(known_val ? val : 24'(res));
            patch_row = 2'd0;
        end
    endtask

    task automatic flag_mismatch(input bit orphan, input logic [23:0] want,
                                 input logic [23:0] got);
        mismatches++;
        if (mismatches <= 10)
        begin
            if (orphan)
                $display("%0t: result 0x%06h arrived with nothing expected", $realtime, got);
            else
                $display("%0t: interp_value expected 0x%06h, got 0x%06h",
                         $realtime, want, got);
        end
    endtask

    // Receiver: stalls at the current rate, except for one long hold-off that the stimulus
    // arms; the hold is counted here so the sender keeps offering rows meanwhile.
    always @(posedge clk)
    begin
        if (hold_armed && !hold_taken)
        begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every accepted result is compared with the oldest value owed. Signals are read just
    // after the edge, so they hold what the block presented at that edge.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_values.size() == 0)
                flag_mismatch(1'b1, 24'h0, m_axis_tdata[23:0]);
            else
            begin
                owed_value = expected_values.pop_front();
                if (m_axis_tdata[23:0] !== owed_value)
                    flag_mismatch(1'b0, owed_value, m_axis_tdata[23:0]);
            end
        end
    end

    // Watchdog: a long run of cycles in which neither side moves a request means a hang.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int phase, p, r, j, style;
        logic [23:0] smp [4];
        logic [23:0] base;

        patch_row = 2'd0;
        for (j = 0; j < 3; j++)
            row_values[j] = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The sender idles rarely and the receiver often during the directed rows and the
        // first random phase, the other way round in the second, and not at all in the third.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 8;
                    recv_idle_pct = 82;
                end
                1:
                begin
                    send_idle_pct = 82;
                    recv_idle_pct = 8;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // With the receiver held off and rows offered back to back, the block
                    // fills up and must stall its input.
                    hold_armed = 1'b1;
                end
            endcase

            if (phase == 0)
            begin
                foreach (directed_rows[i])
                    send_row(directed_rows[i].s0, directed_rows[i].s1, directed_rows[i].s2,
                             directed_rows[i].s3, directed_rows[i].fcol,
                             directed_rows[i].frow, directed_rows[i].known_val,
                             directed_rows[i].val);
            end

            // Each random patch draws its samples in one style: fully random, extremes only,
            // a smooth surface around a base level, or small values near zero.
            for (p = 0; p < PATCHES_PER_PHASE; p++)
            begin
                style = $urandom_range(0, 3);
                base  = 24'($urandom);
                for (r = 0; r < 4; r++)
                begin
                    for (j = 0; j < 4; j++)
                    begin
                        case (style)
                            0:       smp[j] = 24'($urandom);
                            1:       smp[j] = $urandom_range(0, 1) ? SMAX : 24'h000000;
                            2:       smp[j] = base + 24'($urandom_range(0, 8191)) - 24'd4096;
                            default: smp[j] = 24'($urandom_range(0, 255));
                        endcase
                    end
                    send_row(smp[0], smp[1], smp[2], smp[3], pick_frac(), pick_frac(),
                             1'b0, 24'h0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge clk);
        // Leave room for any stray result to show up.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_values.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
